// ----- src/totp_pkg.sv -----
package totp_pkg;

    localparam int DataW = 32;
    localparam int DivisorW = 20;
    localparam int CodeW = 20;
    localparam int StepW = 16;
    localparam int KeyW = 160;
    localparam int BlockW = 512;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [DivisorW-1:0] CODE_MOD = 20'd1000000;
    localparam logic [63:0] INNER_BITS = 64'd576;
    localparam logic [63:0] OUTER_BITS = 64'd672;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_MID = 2'd1;
    localparam logic [1:0] REG_KEY_LOW = 2'd2;
    localparam logic [1:0] REG_TIME_STEP = 2'd3;

    localparam logic [1:0] BLK_INNER_PAD = 2'd0;
    localparam logic [1:0] BLK_INNER_MSG = 2'd1;
    localparam logic [1:0] BLK_OUTER_PAD = 2'd2;
    localparam logic [1:0] BLK_OUTER_MSG = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_WAIT,
        ST_HASH_WAIT,
        ST_MOD_WAIT
    } totp_state_t;

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (rnd < 7'd40)
        begin
            f = b ^ c ^ d;
        end
        else if (rnd < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)
        begin
            k = 32'h5A827999;
        end
        else if (rnd < 7'd40)
        begin
            k = 32'h6ED9EBA1;
        end
        else if (rnd < 7'd60)
        begin
            k = 32'h8F1BBCDC;
        end
        else
        begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// ----- src/totp_hmac_sha1_code.sv -----
// Channel   Direction  Signals                          Handshake
// command   in         time_seconds                     start high while busy low
// result    out        code                             done strobe, one cycle
// config    in         cfg_index, cfg_data              cfg_write, no wait
//
// Each word passes through the shared divider to form the counter, the four
// compressions on the SHA-1 round unit, the same divider to reduce the
// truncated value modulo one million, and the registered result strobe.
// Reset restores the default key and time step and leaves the block idle.
// The receiver cannot stall: code is valid in the cycle done is high, and is held until the next result.
module totp_hmac_sha1_code
    import totp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DataW-1:0]  time_seconds,
    output logic              busy,
    output logic              done,
    output logic [CodeW-1:0]  code,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    totp_state_t state_reg, state_next;
    logic [63:0]      key_high_reg, key_mid_reg;
    logic [31:0]      key_low_reg;
    logic [StepW-1:0] step_reg;
    logic [1:0]       blk_reg, blk_next;
    logic [63:0]      counter_reg, counter_next;
    logic [159:0]     h_reg, h_next;
    logic [159:0]     inner_reg, inner_next;
    logic             done_reg, done_next;
    logic [CodeW-1:0] code_reg, code_next;

    logic                div_start, div_done;
    logic [DataW-1:0]    div_dividend, div_quotient;
    logic [DivisorW-1:0] div_divisor, div_remainder;
    logic                sha_start, sha_done;
    logic [1:0]          sha_sel;
    logic [BlockW-1:0]   sha_block;
    logic [159:0]        sha_hout;
    logic [KeyW-1:0]     key;
    logic [159:0]        dig_shift;

    assign key = {key_high_reg, key_mid_reg, key_low_reg};

    always_comb
    begin
        unique case (sha_sel)
            BLK_INNER_PAD: sha_block = {key ^ {20{IPAD_BYTE}}, {44{IPAD_BYTE}}};
            BLK_INNER_MSG: sha_block = {counter_reg, PAD_MARK, 376'b0, INNER_BITS};
            BLK_OUTER_PAD: sha_block = {key ^ {20{OPAD_BYTE}}, {44{OPAD_BYTE}}};
            BLK_OUTER_MSG: sha_block = {inner_reg, PAD_MARK, 280'b0, OUTER_BITS};
            default:       sha_block = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next = blk_reg;
        counter_next = counter_reg;
        h_next = h_reg;
        inner_next = inner_reg;
        done_next = 1'b0;
        code_next = code_reg;
        div_start = 1'b0;
        div_dividend = time_seconds;
        div_divisor = (step_reg == '0) ? DivisorW'(1) : DivisorW'(step_reg);
        sha_start = 1'b0;
        sha_sel = BLK_INNER_PAD;
        dig_shift = sha_hout << {sha_hout[3:0], 3'b000};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    counter_next = {32'b0, div_quotient};
                    h_next = SHA1_IV;
                    blk_next = BLK_INNER_PAD;
                    sha_sel = BLK_INNER_PAD;
                    sha_start = 1'b1;
                    state_next = ST_HASH_WAIT;
                end
            end
            ST_HASH_WAIT:
            begin
                if (sha_done)
                begin
                    if (blk_reg == BLK_OUTER_MSG)
                    begin
                        div_start = 1'b1;
                        div_dividend = {1'b0, dig_shift[158:128]};
                        div_divisor = CODE_MOD;
                        state_next = ST_MOD_WAIT;
                    end
                    else
                    begin
                        if (blk_reg == BLK_INNER_MSG)
                        begin
                            inner_next = sha_hout;
                            h_next = SHA1_IV;
                        end
                        else
                        begin
                            h_next = sha_hout;
                        end
                        blk_next = blk_reg + 2'd1;
                        sha_sel = blk_reg + 2'd1;
                        sha_start = 1'b1;
                    end
                end
            end
            ST_MOD_WAIT:
            begin
                if (div_done)
                begin
                    code_next = div_remainder;
                    done_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
            blk_reg <= BLK_INNER_PAD;
            key_high_reg <= 64'd3617859138015688753;
            key_mid_reg <= 64'd3834869380612813616;
            key_low_reg <= 32'd926431280;
            step_reg <= 16'd5;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            blk_reg <= blk_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_KEY_HIGH:  key_high_reg <= cfg_data;
                    REG_KEY_MID:   key_mid_reg <= cfg_data;
                    REG_KEY_LOW:   key_low_reg <= cfg_data[31:0];
                    REG_TIME_STEP: step_reg <= cfg_data[StepW-1:0];
                    default:       step_reg <= step_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        counter_reg <= counter_next;
        h_reg <= h_next;
        inner_reg <= inner_next;
        code_reg <= code_next;
    end

    totp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    totp_sha1_core u_sha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sha_start),
        .block (sha_block),
        .h_in  (h_next),
        .done  (sha_done),
        .h_out (sha_hout)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign code = code_reg;

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (code < CODE_MOD))
        else $error("code out of range");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_start && sha_start))
        else $error("divider and hash started together");

endmodule

// ----- src/totp_div.sv -----
module totp_div
    import totp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DataW-1:0]    dividend,
    input  logic [DivisorW-1:0] divisor,
    output logic                done,
    output logic [DataW-1:0]    quotient,
    output logic [DivisorW-1:0] remainder
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [DataW-1:0]      quo_reg, quo_next;
    logic [DivisorW-1:0]   rem_reg, rem_next;
    logic [DivisorW-1:0]   div_reg, div_next;
    logic [DivisorW:0]     trial;
    logic [DivisorW:0]     diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DataW-1]};
        diff = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[DivisorW-1:0];
                quo_next = {quo_reg[DataW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DivisorW-1:0];
                quo_next = {quo_reg[DataW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/totp_sha1_core.sv -----
module totp_sha1_core
    import totp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [BlockW-1:0] block,
    input  logic [159:0]      h_in,
    output logic              done,
    output logic [159:0]      h_out
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [31:0]  w_new;
    logic [31:0]  w_mix;
    logic [31:0]  t_sum;
    logic [159:0] h_reg, h_next;

    always_comb
    begin
        w_mix = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        w_new = {w_mix[30:0], w_mix[31]};
        t_sum = {a_reg[26:0], a_reg[31:27]} + sha1_f(rnd_reg, b_reg, c_reg, d_reg)
              + e_reg + sha1_k(rnd_reg) + w_reg[0];
        busy_next = busy_reg;
        done_next = 1'b0;
        rnd_next = rnd_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        h_next = h_reg;
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next = '0;
            {a_next, b_next, c_next, d_next, e_next} = h_in;
            for (int i = 0; i < 16; i++)
            begin
                w_next[i] = block[BlockW-1-32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            if (rnd_reg == 7'd80)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                h_next = {h_in[159:128] + a_reg, h_in[127:96] + b_reg,
                          h_in[95:64] + c_reg, h_in[63:32] + d_reg, h_in[31:0] + e_reg};
            end
            else
            begin
                a_next = t_sum;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                rnd_next = rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        h_reg <= h_next;
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

    assign done = done_reg;
    assign h_out = h_reg;

endmodule

// ----- verif/totp_hmac_sha1_code_test.sv -----
module totp_hmac_sha1_code_test;
    import totp_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic [DataW-1:0]  time_seconds;
    logic              busy;
    logic              done;
    logic [CodeW-1:0]  code;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [63:0]       cfg_data;

    logic [63:0]       key_high_q;
    logic [63:0]       key_mid_q;
    logic [31:0]       key_low_q;
    logic [15:0]       step_q;

    logic [CodeW-1:0]  pending_codes[$];
    int                fail_count;
    int                words_sent;
    int                codes_seen;
    int                cycle_count;
    bit                idle_allowed;

    totp_hmac_sha1_code u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .time_seconds (time_seconds),
        .busy         (busy),
        .done         (done),
        .code         (code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] compress(input logic [159:0] hin,
                                              input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = blk[511 - 32 * i -: 32];
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        {a, b, c, d, e} = hin;
        for (int i = 0; i < 80; i++)
        begin
            t = rotl(a, 5) + sha1_f(i[6:0], b, c, d) + e + sha1_k(i[6:0]) + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        return {hin[159:128] + a, hin[127:96] + b, hin[95:64] + c,
                hin[63:32] + d, hin[31:0] + e};
    endfunction

    function automatic logic [CodeW-1:0] totp_code(input logic [31:0] t);
        logic [159:0] key;
        logic [511:0] ipad, opad, blk;
        logic [159:0] h;
        logic [63:0]  counter;
        logic [31:0]  bin;
        logic [31:0]  divisor;
        int           off;
        key = {key_high_q, key_mid_q, key_low_q};
        ipad = {key, 352'b0} ^ {64{IPAD_BYTE}};
        opad = {key, 352'b0} ^ {64{OPAD_BYTE}};
        divisor = (step_q == 16'd0) ? 32'd1 : {16'd0, step_q};
        counter = {32'd0, t / divisor};
        h = compress(SHA1_IV, ipad);
        blk = {counter, PAD_MARK, 376'b0, INNER_BITS};
        h = compress(h, blk);
        blk = {h, PAD_MARK, 280'b0, OUTER_BITS};
        h = compress(compress(SHA1_IV, opad), blk);
        off = int'(h[3:0]);
        bin = h[159 - 8 * off -: 32] & 32'h7FFFFFFF;
        return CodeW'(bin % 32'd1000000);
    endfunction

    task automatic wait_cycles(input int n);
        repeat (n) @(negedge clk);
    endtask

    task automatic maybe_idle();
        if (idle_allowed && $urandom_range(99) < 8)
        begin
            wait_cycles($urandom_range(1, 40));
        end
    endtask

    task automatic send_time(input logic [31:0] t);
        @(negedge clk);
        maybe_idle();
        start <= 1'b1;
        time_seconds <= t;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_codes.push_back(totp_code(t));
        words_sent++;
        @(negedge clk);
        start <= 1'b0;
        time_seconds <= $urandom;
    endtask

    task automatic drain();
        while (pending_codes.size() != 0)
        begin
            @(negedge clk);
        end
        wait_cycles(450);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data <= {$urandom, $urandom};
        case (idx)
            REG_KEY_HIGH: key_high_q = value;
            REG_KEY_MID: key_mid_q = value;
            REG_KEY_LOW: key_low_q = value[31:0];
            default: step_q = value[15:0];
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [63:0] kh, input logic [63:0] km,
                              input logic [31:0] kl, input logic [15:0] st);
        drain();
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_MID, km);
        write_reg(REG_KEY_LOW, {$urandom, kl});
        write_reg(REG_TIME_STEP, ({$urandom, $urandom} & ~64'hFFFF) | {48'd0, st});
    endtask

    task automatic test_reset_defaults();
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        send_time(32'd4);
        send_time(32'd5);
        send_time(32'd59);
        send_time(32'd1111111109);
    endtask

    task automatic test_extreme_keys();
        set_config(64'd0, 64'd0, 32'd0, 16'd1);
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        set_config('1, '1, '1, 16'hFFFF);
        send_time(32'hFFFF_FFFF);
        send_time(32'd65534);
        send_time(32'd65535);
        set_config(64'h3132333435363738, 64'h3930313233343536, 32'h37383930, 16'd30);
        send_time(32'd59);
        send_time(32'd1111111109);
        send_time(32'd2000000000);
    endtask

    task automatic test_zero_step();
        set_config({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 16'd0);
        send_time(32'd0);
        send_time(32'd1);
        send_time(32'hFFFF_FFFF);
        send_time($urandom);
    endtask

    task automatic test_random_words();
        logic [15:0] st;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: st = 16'd30;
                1: st = 16'($urandom_range(1, 120));
                2: st = 16'($urandom);
                default: st = 16'($urandom_range(0, 3));
            endcase
            set_config({$urandom, $urandom}, {$urandom, $urandom}, $urandom, st);
            idle_allowed = (phase != 2);
            for (int i = 0; i < 80; i++)
            begin
                send_time((i % 5 == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0) :
                          $urandom);
                if (i == 40 && phase == 1)
                begin
                    while (pending_codes.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
            end
        end
        idle_allowed = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            codes_seen++;
            if (pending_codes.size() == 0)
            begin
                $display("%0t: code %0d with no word pending", $time, code);
                fail_count++;
            end
            else if (pending_codes[0] !== code)
            begin
                $display("%0t: code mismatch, expected %0d, actual %0d",
                         $time, pending_codes[0], code);
                fail_count++;
                void'(pending_codes.pop_front());
            end
            else
            begin
                void'(pending_codes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 1500000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        time_seconds = '0;
        cfg_write = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        fail_count = 0;
        words_sent = 0;
        codes_seen = 0;
        cycle_count = 0;
        idle_allowed = 1'b1;
        key_high_q = 64'd3617859138015688753;
        key_mid_q = 64'd3834869380612813616;
        key_low_q = 32'd926431280;
        step_q = 16'd5;
        wait_cycles(12);
        rst_n = 1'b1;
        wait_cycles(2);
        test_reset_defaults();
        test_extreme_keys();
        test_zero_step();
        test_random_words();
        drain();
        $display("Sent %0d time words and checked %0d codes over %0d key and step settings.",
                 words_sent, codes_seen, 13);
        if (fail_count == 0 && pending_codes.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/totp_pkg.sv
src/totp_div.sv
src/totp_sha1_core.sv
src/totp_hmac_sha1_code.sv
verif/totp_hmac_sha1_code_test.sv
